FILE: src/mfw_pkg.sv
// Shared types and constants of the RGB window median filter.
package mfw_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int CFG_W      = 12;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = COL_W + 1;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int HDIM_W     = ROW_W + 1;
	localparam int IDX_W      = COL_W + ROW_W;
	localparam int HELD_W     = $clog2(2 * MAX_WIDTH + 3);
	localparam int NUM_BANKS  = 8;
	localparam int BANK_W     = $clog2(NUM_BANKS);
	localparam int WIN        = 5;
	localparam int WIN_N      = WIN * WIN;
	localparam int RANK_W     = $clog2(WIN_N);
	localparam int MID        = WIN_N / 2;
	localparam int RANK_2X2   = 2;
	localparam int RANK_3X3   = 4;
	localparam int NUM_LANES  = 3;

	localparam logic [1:0] MODE_2X2 = 2'd0;
	localparam logic [1:0] MODE_3X3 = 2'd1;
	localparam logic [1:0] MODE_5X5 = 2'd2;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef logic [7:0] pix_t;
	// lane 0 red, lane 1 green, lane 2 blue
	typedef logic [NUM_LANES-1:0][7:0] rgb_t;
	typedef logic [WIN_N-1:0][7:0] win_vals_t;

	typedef struct packed {
		logic en3;
		logic en4;
		logic en5;
	} lane_en_t;

endpackage

FILE: src/mfw_line_bank.sv
// One row bank of the line store: one write port, two registered read ports.
module mfw_line_bank import mfw_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [COL_W-1:0] waddr,
	input  rgb_t             wdata,
	input  logic             re,
	input  logic [COL_W-1:0] raddr_a,
	output rgb_t             rdata_a,
	input  logic [COL_W-1:0] raddr_b,
	output rgb_t             rdata_b
);

	rgb_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: src/mfw_lane.sv
// Rank lane: picks the middle value of 25 window values for one color channel.
module mfw_lane import mfw_pkg::*; (
	input  logic      clk,
	input  lane_en_t  en,
	input  win_vals_t vals,
	output pix_t      median
);

	logic [WIN_N-1:0]  below_c [WIN_N];
	logic [WIN_N-1:0]  below_s3 [WIN_N];
	win_vals_t         vals_s3;
	win_vals_t         vals_s4;
	logic [RANK_W-1:0] rank_s4 [WIN_N];
	pix_t              median_c;
	pix_t              median_s5;

	// ties break on element order so every rank is taken exactly once
	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			for (int j = 0; j < WIN_N; j++) begin
				if (j == i) begin
					below_c[i][j] = 1'b0;
				end else if (j < i) begin
					below_c[i][j] = (vals[j] <= vals[i]);
				end else begin
					below_c[i][j] = (vals[j] < vals[i]);
				end
			end
		end
	end

	always_comb begin
		median_c = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (rank_s4[i] == RANK_W'(MID)) begin
				median_c = median_c | vals_s4[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.en3) begin
			below_s3 <= below_c;
			vals_s3  <= vals;
		end
		if (en.en4) begin
			for (int i = 0; i < WIN_N; i++) begin
				rank_s4[i] <= RANK_W'($countones(below_s3[i]));
			end
			vals_s4 <= vals_s3;
		end
		if (en.en5) begin
			median_s5 <= median_c;
		end
	end

	assign median = median_s5;

endmodule

FILE: src/median_filter_window_rgb_unit.sv
// Top level of the streaming RGB median filter with 2x2, 3x3 and 5x5 windows.
// Throughput: one input transfer per cycle unless out_ready stalls the five-stage pipeline;
// mode 1 holds width+1 pixels, mode 2 holds 2*width+2 pixels, mode 0 releases each pixel at once.
// Reset: arst_n clears positions, counts and valids and loads mode 1, 640 x 480.
// The line store is not cleared; no pass runs after reset.
module median_filter_window_rgb_unit import mfw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [7:0]       in_red,
	input  logic [7:0]       in_green,
	input  logic [7:0]       in_blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic             frame_last
);

	localparam int CW = (CFG_W > DIM_W) ? CFG_W : DIM_W;
	localparam int CH = (CFG_W > HDIM_W) ? CFG_W : HDIM_W;

	// elements kept by each window shape; the rest are padded
	function automatic logic [WIN_N-1:0] keep_mask(input logic [1:0] mode);
		logic [WIN_N-1:0] m;
		m = '0;
		for (int k = 0; k < WIN; k++) begin
			for (int c = 0; c < WIN; c++) begin
				if (mode == MODE_2X2) begin
					m[k*WIN+c] = (k >= 2) && (k <= 3) && (c >= 3);
				end else if (mode == MODE_3X3) begin
					m[k*WIN+c] = (k >= 1) && (k <= 3) && (c >= 2);
				end else begin
					m[k*WIN+c] = 1'b1;
				end
			end
		end
		return m;
	endfunction

	// the first n_low padded elements become zero, the others full scale,
	// so the middle rank of 25 lands on the wanted rank of the kept set
	function automatic logic [WIN_N-1:0] low_mask(input logic [1:0] mode, input int n_low);
		logic [WIN_N-1:0] m;
		logic [WIN_N-1:0] kp;
		int               cnt;
		m   = '0;
		kp  = keep_mask(mode);
		cnt = 0;
		for (int e = 0; e < WIN_N; e++) begin
			if (!kp[e] && cnt < n_low) begin
				m[e] = 1'b1;
				cnt  = cnt + 1;
			end
		end
		return m;
	endfunction

	localparam logic [WIN_N-1:0] KEEP_2X2 = keep_mask(MODE_2X2);
	localparam logic [WIN_N-1:0] KEEP_3X3 = keep_mask(MODE_3X3);
	localparam logic [WIN_N-1:0] LOW_2X2  = low_mask(MODE_2X2, MID - RANK_2X2);
	localparam logic [WIN_N-1:0] LOW_3X3  = low_mask(MODE_3X3, MID - RANK_3X3);

	// configuration
	logic [1:0]       mode_q;
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             restart;
	logic [1:0]       mode_after;
	logic [1:0]       ld_init;

	// frame geometry
	logic [CW-1:0]     width_ext;
	logic [CH-1:0]     height_ext;
	logic [DIM_W-1:0]  w_dim;
	logic [HDIM_W-1:0] h_dim;
	logic              small_win;
	logic [1:0]        rad;
	logic [1:0]        ld_off;
	logic [HELD_W-1:0] lead;

	// positions and counts
	logic [COL_W-1:0]  in_col_q, in_col_n;
	logic [ROW_W-1:0]  in_row_q, in_row_n;
	logic [IDX_W-1:0]  in_idx_q, in_idx_n;
	logic [BANK_W-1:0] wr_line_q, wr_line_n;
	logic [HELD_W-1:0] held_q, held_n;
	logic [COL_W-1:0]  out_col_q, out_col_n;
	logic [ROW_W-1:0]  out_row_q, out_row_n;
	logic [BANK_W-1:0] out_line_q, out_line_n;
	logic [COL_W-1:0]  ld_col_q, ld_col_n;
	logic [BANK_W-1:0] ld_line_q, ld_line_n;
	logic [DIM_W-1:0]  in_col_inc, out_col_inc, ld_col_inc;
	logic [HDIM_W-1:0] in_row_inc, out_row_inc;
	logic              pixel, transfer_in, wr, emit, emit_go;
	logic              in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap, ld_col_wrap;
	logic              inner, last_px;

	// pipeline control
	logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
	logic mv1, mv2, mv3, mv4, mv5;
	logic free1, free2, free3, free4, free5, free_o;
	lane_en_t lane_en;

	// line store
	rgb_t wdata;
	rgb_t rd_a [NUM_BANKS];
	rgb_t rd_b [NUM_BANKS];

	// stage 1
	logic [BANK_W-1:0] row_bank0_s1, raw_bank_s1, byp_bank_s1;
	logic              byp_ld_s1, byp_raw_s1, inner_s1, last_s1;
	rgb_t              wdata_s1;
	rgb_t              col_c [WIN];
	rgb_t              raw_c;

	// window and later stages
	rgb_t             win_q  [WIN][WIN];
	rgb_t             win_nx [WIN][WIN];
	logic [WIN_N-1:0] keep_m, low_m;
	win_vals_t        vals_c  [NUM_LANES];
	win_vals_t        vals_s2 [NUM_LANES];
	rgb_t             raw_s2, raw_s3, raw_s4, raw_s5;
	logic             inner_s2, inner_s3, inner_s4, inner_s5;
	logic             last_s2, last_s3, last_s4, last_s5;
	pix_t             median [NUM_LANES];
	rgb_t             out_pix_q;
	logic             frame_last_q;

	// configuration writes restart the frame
	assign restart    = cfg_write_en && (cfg_index == CFG_MODE || cfg_index == CFG_WIDTH ||
	                                     cfg_index == CFG_HEIGHT);
	assign mode_after = (cfg_write_en && cfg_index == CFG_MODE) ? cfg_data[1:0] : mode_q;
	assign ld_init    = (mode_after == MODE_2X2) ? 2'd0 : (mode_after[1] ? 2'd2 : 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_3X3;
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate the frame size, derive radius and how far the input runs ahead
	assign width_ext  = CW'(width_q);
	assign height_ext = CH'(height_q);
	assign w_dim = (width_q == '0) ? DIM_W'(1) :
	               (width_ext > CW'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_ext);
	assign h_dim = (height_q == '0) ? HDIM_W'(1) :
	               (height_ext > CH'(MAX_HEIGHT)) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(height_ext);
	assign small_win = (mode_q == MODE_2X2);
	assign rad       = mode_q[1] ? 2'd2 : 2'd1;
	assign ld_off    = small_win ? 2'd0 : rad;
	assign lead      = small_win ? '0 :
	                   mode_q[1] ? ((HELD_W'(w_dim) << 1) + HELD_W'(2)) : (HELD_W'(w_dim) + HELD_W'(1));

	// input side: write position, frame index, held count
	assign pixel       = ~action;
	assign transfer_in = in_valid && in_ready;
	assign wr          = transfer_in && pixel;
	assign in_col_inc  = DIM_W'(in_col_q) + DIM_W'(1);
	assign in_row_inc  = HDIM_W'(in_row_q) + HDIM_W'(1);
	assign in_col_wrap = (in_col_inc >= w_dim);
	assign in_row_wrap = (in_row_inc >= h_dim);

	always_comb begin
		in_col_n  = in_col_q;
		in_row_n  = in_row_q;
		in_idx_n  = in_idx_q;
		wr_line_n = wr_line_q;
		if (pixel) begin
			in_col_n = in_col_wrap ? '0 : in_col_inc[COL_W-1:0];
			in_idx_n = (in_col_wrap && in_row_wrap) ? '0 : in_idx_q + IDX_W'(1);
			if (in_col_wrap) begin
				in_row_n  = in_row_wrap ? '0 : in_row_inc[ROW_W-1:0];
				wr_line_n = wr_line_q + BANK_W'(1);
			end
		end
	end

	// release the oldest held pixel once its window is in, or once its frame is complete
	assign held_n  = held_q + HELD_W'(pixel);
	assign emit    = (held_n != '0) && ((IDX_W'(held_n) > in_idx_n) || (held_n > lead));
	assign emit_go = transfer_in && emit;

	// output side: released position and the column the window loads
	assign out_col_inc  = DIM_W'(out_col_q) + DIM_W'(1);
	assign out_row_inc  = HDIM_W'(out_row_q) + HDIM_W'(1);
	assign ld_col_inc   = DIM_W'(ld_col_q) + DIM_W'(1);
	assign out_col_wrap = (out_col_inc >= w_dim);
	assign out_row_wrap = (out_row_inc >= h_dim);
	assign ld_col_wrap  = (ld_col_inc >= w_dim);

	always_comb begin
		out_col_n  = out_col_wrap ? '0 : out_col_inc[COL_W-1:0];
		out_row_n  = out_row_q;
		out_line_n = out_line_q;
		if (out_col_wrap) begin
			out_row_n  = out_row_wrap ? '0 : out_row_inc[ROW_W-1:0];
			out_line_n = out_line_q + BANK_W'(1);
		end
		ld_col_n  = ld_col_wrap ? '0 : ld_col_inc[COL_W-1:0];
		ld_line_n = ld_line_q + BANK_W'(ld_col_wrap);
	end

	assign inner = (out_col_q >= COL_W'(rad)) && ((DIM_W'(out_col_q) + DIM_W'(rad)) < w_dim) &&
	               (out_row_q >= ROW_W'(rad)) && ((HDIM_W'(out_row_q) + HDIM_W'(rad)) < h_dim);
	assign last_px = (DIM_W'(out_col_q) == w_dim - DIM_W'(1)) &&
	                 (HDIM_W'(out_row_q) == h_dim - HDIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_idx_q   <= '0;
			wr_line_q  <= '0;
			held_q     <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_line_q <= '0;
			ld_col_q   <= COL_W'(1);
			ld_line_q  <= '0;
		end else if (restart) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_idx_q   <= '0;
			wr_line_q  <= '0;
			held_q     <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_line_q <= '0;
			ld_col_q   <= COL_W'(ld_init);
			ld_line_q  <= '0;
		end else if (transfer_in) begin
			in_col_q  <= in_col_n;
			in_row_q  <= in_row_n;
			in_idx_q  <= in_idx_n;
			wr_line_q <= wr_line_n;
			held_q    <= held_n - HELD_W'(emit);
			if (emit) begin
				out_col_q  <= out_col_n;
				out_row_q  <= out_row_n;
				out_line_q <= out_line_n;
				ld_col_q   <= ld_col_n;
				ld_line_q  <= ld_line_n;
			end
		end
	end

	// pipeline advance: a stage moves when the one after it is empty or moving
	assign free_o = !out_valid_q || out_ready;
	assign mv5    = v5_q && free_o;
	assign free5  = !v5_q || mv5;
	assign mv4    = v4_q && free5;
	assign free4  = !v4_q || mv4;
	assign mv3    = v3_q && free4;
	assign free3  = !v3_q || mv3;
	assign mv2    = v2_q && free3;
	assign free2  = !v2_q || mv2;
	assign mv1    = v1_q && free2;
	assign free1  = !v1_q || mv1;
	assign in_ready = free1;

	assign lane_en.en3 = mv2;
	assign lane_en.en4 = mv3;
	assign lane_en.en5 = mv4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			v5_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				v1_q <= 1'b1;
			end else if (mv1) begin
				v1_q <= 1'b0;
			end
			if (mv1) begin
				v2_q <= 1'b1;
			end else if (mv2) begin
				v2_q <= 1'b0;
			end
			if (mv2) begin
				v3_q <= 1'b1;
			end else if (mv3) begin
				v3_q <= 1'b0;
			end
			if (mv3) begin
				v4_q <= 1'b1;
			end else if (mv4) begin
				v4_q <= 1'b0;
			end
			if (mv4) begin
				v5_q <= 1'b1;
			end else if (mv5) begin
				v5_q <= 1'b0;
			end
			if (mv5) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// line store: one bank per row, rows rotate through the banks across frames;
	// every bank reads the load column and the released pixel's column together
	assign wdata = {in_blue, in_green, in_red};

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		mfw_line_bank u_bank (
			.clk     (clk),
			.we      (wr && (wr_line_q == BANK_W'(b))),
			.waddr   (in_col_q),
			.wdata   (wdata),
			.re      (emit_go),
			.raddr_a (ld_col_q),
			.rdata_a (rd_a[b]),
			.raddr_b (out_col_q),
			.rdata_b (rd_b[b])
		);
	end

	// stage 1: remember bank mapping and forward the pixel written in the read cycle
	always_ff @(posedge clk) begin
		if (emit_go) begin
			row_bank0_s1 <= ld_line_q - BANK_W'(2) - BANK_W'(small_win);
			raw_bank_s1  <= out_line_q;
			byp_bank_s1  <= wr_line_q;
			byp_ld_s1    <= pixel && (in_col_q == ld_col_q);
			byp_raw_s1   <= pixel && (in_col_q == out_col_q) && (wr_line_q == out_line_q);
			wdata_s1     <= wdata;
			inner_s1     <= inner;
			last_s1      <= last_px;
		end
	end

	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			logic [BANK_W-1:0] bk;
			bk = row_bank0_s1 + BANK_W'(k);
			col_c[k] = (byp_ld_s1 && bk == byp_bank_s1) ? wdata_s1 : rd_a[bk];
		end
		raw_c = byp_raw_s1 ? wdata_s1 : rd_b[raw_bank_s1];
	end

	// shift the window one column and pad the unused elements for the lanes
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			for (int c = 0; c < WIN - 1; c++) begin
				win_nx[k][c] = win_q[k][c+1];
			end
			win_nx[k][WIN-1] = col_c[k];
		end
	end

	always_comb begin
		if (mode_q == MODE_2X2) begin
			keep_m = KEEP_2X2;
			low_m  = LOW_2X2;
		end else if (mode_q == MODE_3X3) begin
			keep_m = KEEP_3X3;
			low_m  = LOW_3X3;
		end else begin
			keep_m = '1;
			low_m  = '0;
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			for (int k = 0; k < WIN; k++) begin
				for (int c = 0; c < WIN; c++) begin
					if (keep_m[k*WIN+c]) begin
						vals_c[l][k*WIN+c] = win_nx[k][c][l];
					end else begin
						vals_c[l][k*WIN+c] = low_m[k*WIN+c] ? 8'h00 : 8'hFF;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			win_q    <= win_nx;
			vals_s2  <= vals_c;
			raw_s2   <= raw_c;
			inner_s2 <= inner_s1;
			last_s2  <= last_s1;
		end
		if (mv2) begin
			raw_s3   <= raw_s2;
			inner_s3 <= inner_s2;
			last_s3  <= last_s2;
		end
		if (mv3) begin
			raw_s4   <= raw_s3;
			inner_s4 <= inner_s3;
			last_s4  <= last_s3;
		end
		if (mv4) begin
			raw_s5   <= raw_s4;
			inner_s5 <= inner_s4;
			last_s5  <= last_s4;
		end
	end

	// one rank lane per color channel
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		mfw_lane u_lane (
			.clk    (clk),
			.en     (lane_en),
			.vals   (vals_s2[l]),
			.median (median[l])
		);
	end

	// merge: inner pixels take the lane results, border pixels pass unchanged
	always_ff @(posedge clk) begin
		if (mv5) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				out_pix_q[l] <= inner_s5 ? median[l] : raw_s5[l];
			end
			frame_last_q <= last_s5;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_pix_q[0];
	assign out_green  = out_pix_q[1];
	assign out_blue   = out_pix_q[2];
	assign frame_last = frame_last_q;

	// never more pixels held back than the window lead
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= lead) else $error("held count beyond window lead");

	// a released pixel enters stage 1
	a_emit_enters: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> v1_q) else $error("released pixel lost at stage 1");

	// a stalled stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && !mv1) |=> v1_q) else $error("stage 1 item dropped");

	// stage 5 moving fills the output register
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mv5 |=> out_valid_q) else $error("result lost at output register");

	// positions stay inside the row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W'(in_col_q) < w_dim) && (DIM_W'(out_col_q) < w_dim))
		else $error("column position beyond row width");

endmodule
